### sv/text_to_unsigned_integer_parser_unit_assert.svh
// Assertion macros shared by the parser unit.
`ifndef TEXT_TO_UNSIGNED_INTEGER_PARSER_UNIT_ASSERT_SVH
`define TEXT_TO_UNSIGNED_INTEGER_PARSER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TTU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser unit: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define TTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser unit: next-cycle check failed");

`endif

### sv/ttu_pkg.sv
package ttu_pkg;

  // Character codes
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Radix values
  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] BASE_MAX  = 6'd36;
  localparam logic [5:0] LETTER_OFFSET = 6'd10;

  // Digit value of a character that is no digit at all; above every radix
  localparam logic [5:0] NO_DIGIT = 6'h3F;

  // Token queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_POSTSIGN,
    PH_ZERO,
    PH_HEXX,
    PH_DIGITS
  } ttu_phase_e;

  // Classified character
  typedef struct packed {
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic [5:0] dval;
  } ttu_tok_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic               push;
    logic [Q_CNT_W-1:0] count;
  } ttu_q_stat_t;

endpackage

### sv/ttu_ifs.sv
// Character request channel
interface ttu_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink (input valid, input text_char, output ready);
endinterface

// Parse result channel
interface ttu_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] parsed_value;
  logic [15:0] end_offset;
  logic        converted;

  modport source (output valid, output parsed_value, output end_offset, output converted,
                  input ready);
  modport sink (input valid, input parsed_value, input end_offset, input converted,
                output ready);
endinterface

### sv/ttu_front.sv
module ttu_front
  import ttu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ttu_char_if.sink    char_i,
  input  logic        pop_i,
  output ttu_tok_t    tok_o,
  output logic        tok_valid_o,
  output ttu_q_stat_t stat_o
);

  ttu_tok_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   count_q, count_d;
  ttu_tok_t             tok_in;
  logic                 push;
  logic [7:0]           c;

  // Classify the incoming character
  always_comb begin
    c = char_i.text_char;
    tok_in.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    tok_in.is_plus  = (c == CH_PLUS);
    tok_in.is_minus = (c == CH_MINUS);
    tok_in.is_zero  = (c == CH_ZERO);
    tok_in.is_x     = (c == CH_LOWER_X);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      tok_in.dval = 6'(c - CH_ZERO);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      tok_in.dval = 6'(c - CH_UPPER_A) + LETTER_OFFSET;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      tok_in.dval = 6'(c - CH_LOWER_A) + LETTER_OFFSET;
    end else begin
      tok_in.dval = NO_DIGIT;
    end
  end

  assign char_i.ready = (count_q != Q_CNT_W'(Q_DEPTH));
  assign push         = char_i.valid && char_i.ready;
  assign tok_o        = mem_q[rd_ptr_q];
  assign tok_valid_o  = (count_q != '0);
  assign stat_o.push  = push;
  assign stat_o.count = count_q;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified character
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= tok_in;
    end
  end

endmodule

### sv/ttu_back.sv
module ttu_back
  import ttu_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [5:0]   number_base_i,
  input  ttu_tok_t     tok_i,
  input  logic         tok_valid_i,
  output logic         pop_o,
  ttu_result_if.source result_o
);

  localparam int unsigned POS_W = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;

  ttu_phase_e       phase_q, phase_d;
  logic             minus_q, minus_d;
  logic [5:0]       base_q, base_d;
  logic [63:0]      acc_q, acc_d;
  logic             seen_q, seen_d;
  logic [POS_W-1:0] pos_q, pos_d;

  logic             out_valid_q, out_valid_d;
  logic [63:0]      out_value_q;
  logic [15:0]      out_offset_q;
  logic             out_conv_q;

  logic             fire;
  logic [5:0]       sat_base;
  logic [POS_W:0]   pos_sum1, pos_sum2;
  logic [POS_W-1:0] pos_inc1, pos_inc2;
  logic             fc_en;
  logic [5:0]       fc_base;
  logic             td_en;
  logic [5:0]       td_base;
  logic             td_acc_zero;
  logic [63:0]      mul_acc;
  logic [63:0]      prod;
  logic             emit;
  logic [63:0]      emit_acc;
  logic             emit_seen;

  assign fire  = tok_valid_i && (!out_valid_q || result_o.ready);
  assign pop_o = fire;

  assign sat_base = (number_base_i > BASE_MAX) ? BASE_MAX : number_base_i;

  // Saturating position bumps; the carry marks the saturation point
  assign pos_sum1 = {1'b0, pos_q} + (POS_W + 1)'(1);
  assign pos_sum2 = {1'b0, pos_q} + (POS_W + 1)'(2);
  assign pos_inc1 = pos_sum1[POS_W] ? '1 : pos_sum1[POS_W-1:0];
  assign pos_inc2 = pos_sum2[POS_W] ? '1 : pos_sum2[POS_W-1:0];

  // Shared digit multiply-accumulate
  assign mul_acc = td_acc_zero ? '0 : acc_q;
  assign prod    = mul_acc * 64'(td_base) + 64'(tok_i.dval);

  // Parse state and result selection
  always_comb begin
    phase_d     = phase_q;
    minus_d     = minus_q;
    base_d      = base_q;
    acc_d       = acc_q;
    seen_d      = seen_q;
    pos_d       = pos_q;
    fc_en       = 1'b0;
    fc_base     = base_q;
    td_en       = 1'b0;
    td_base     = base_q;
    td_acc_zero = 1'b0;
    emit        = 1'b0;
    emit_acc    = acc_q;
    emit_seen   = seen_q;

    case (phase_q)
      PH_POSTSIGN: begin
        if (tok_i.is_space) begin
          pos_d = pos_inc1;
        end else begin
          fc_en   = 1'b1;
          fc_base = base_q;
        end
      end
      PH_ZERO: begin
        if (tok_i.is_x) begin
          base_d  = BASE_HEX;
          phase_d = PH_HEXX;
        end else begin
          base_d      = (base_q == BASE_AUTO) ? BASE_OCT : base_q;
          seen_d      = 1'b1;
          acc_d       = '0;
          phase_d     = PH_DIGITS;
          td_en       = 1'b1;
          td_base     = base_d;
          td_acc_zero = 1'b1;
          emit_acc    = '0;
          emit_seen   = 1'b1;
        end
      end
      PH_HEXX: begin
        if (tok_i.dval < BASE_HEX) begin
          acc_d   = 64'(tok_i.dval);
          seen_d  = 1'b1;
          pos_d   = pos_inc2;
          phase_d = PH_DIGITS;
        end else begin
          emit      = 1'b1;
          emit_acc  = '0;
          emit_seen = 1'b1;
        end
      end
      PH_DIGITS: begin
        td_en   = 1'b1;
        td_base = base_q;
      end
      default: begin
        // Leading whitespace; also covers codes with no phase
        phase_d = PH_LEAD;
        base_d  = sat_base;
        if (tok_i.is_space) begin
          pos_d = pos_inc1;
        end else if (tok_i.is_plus || tok_i.is_minus) begin
          minus_d = tok_i.is_minus;
          pos_d   = pos_inc1;
          phase_d = PH_POSTSIGN;
        end else begin
          fc_en   = 1'b1;
          fc_base = sat_base;
        end
      end
    endcase

    // First character of the subject: zero marks octal or hex prefix
    if (fc_en) begin
      if (tok_i.is_zero && (fc_base == BASE_AUTO || fc_base == BASE_HEX)) begin
        pos_d   = pos_inc1;
        phase_d = PH_ZERO;
      end else begin
        base_d  = (fc_base == BASE_AUTO) ? BASE_DEC : fc_base;
        phase_d = PH_DIGITS;
        td_en   = 1'b1;
        td_base = base_d;
      end
    end

    // Take a digit of the active radix, or end the number
    if (td_en) begin
      if (tok_i.dval < td_base) begin
        acc_d  = prod;
        seen_d = 1'b1;
        pos_d  = pos_inc1;
      end else begin
        emit = 1'b1;
      end
    end

    // Drop the parse after a result
    if (emit) begin
      phase_d = PH_LEAD;
      minus_d = 1'b0;
      acc_d   = '0;
      seen_d  = 1'b0;
      pos_d   = '0;
    end
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      minus_q     <= 1'b0;
      base_q      <= '0;
      acc_q       <= '0;
      seen_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        phase_q <= phase_d;
        minus_q <= minus_d;
        base_q  <= base_d;
        acc_q   <= acc_d;
        seen_q  <= seen_d;
        pos_q   <= pos_d;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_value_q  <= minus_q ? (64'd0 - emit_acc) : emit_acc;
      out_offset_q <= emit_seen ? 16'(pos_q) : 16'd0;
      out_conv_q   <= emit_seen;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.parsed_value = out_value_q;
  assign result_o.end_offset   = out_offset_q;
  assign result_o.converted    = out_conv_q;

endmodule

### sv/text_to_unsigned_integer_parser_unit.sv
// Flow: a character enters the token queue on acceptance and is parsed when the parser
// pops it; a stop character's result is registered as it is parsed and held until taken.
// Throughput: one character per cycle while no result waits, via the multiply-accumulate.
// A waiting result stalls the parser only; the two-entry token queue takes input until full.
// Reset: asynchronous, active low; clears the queue, the parse state, the pending
// result and the base register (automatic radix).
`include "text_to_unsigned_integer_parser_unit_assert.svh"

module text_to_unsigned_integer_parser_unit
  import ttu_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [5:0]   cfg_wdata_i,
  ttu_char_if.sink     char_i,
  ttu_result_if.source result_o
);

  logic [5:0]  number_base_q;
  ttu_tok_t    tok;
  logic        tok_valid;
  logic        pop;
  ttu_q_stat_t q_stat;

  // Hold the radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= '0;
    end else if (cfg_we_i) begin
      number_base_q <= cfg_wdata_i;
    end
  end

  ttu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_i),
    .pop_i       (pop),
    .tok_o       (tok),
    .tok_valid_o (tok_valid),
    .stat_o      (q_stat)
  );

  ttu_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .number_base_i (number_base_q),
    .tok_i         (tok),
    .tok_valid_i   (tok_valid),
    .pop_o         (pop),
    .result_o      (result_o)
  );

  // A result without conversion carries neither value nor offset
  `TTU_ASSERT_NOW(a_noconv_zero, clk_i, rst_ni,
                  result_o.valid && !result_o.converted,
                  result_o.parsed_value == 64'd0 && result_o.end_offset == 16'd0)

  // Queue occupancy follows the push and pop requests
  `TTU_ASSERT_NEXT(a_q_grow, clk_i, rst_ni, q_stat.push && !pop,
                   q_stat.count == $past(q_stat.count) + 1'b1)

  `TTU_ASSERT_NEXT(a_q_shrink, clk_i, rst_ni, pop && !q_stat.push,
                   q_stat.count == $past(q_stat.count) - 1'b1)

endmodule
